/* rtl/core/fvnh_pkg.sv */
package fvnh_pkg;

  localparam int COORD_BITS  = 12;
  localparam int MAX_OCTAVES = 8;
  localparam int FRAC_BITS   = 20;
  localparam int FREQ_W      = 24;
  localparam int SEED_W      = 32;
  localparam int OCTCFG_W    = 4;
  localparam int SCALE_W     = 16;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int PROD_W = COORD_BITS + FREQ_W;
  localparam int SUM_W  = 34;
  localparam int OIDX_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int CNT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int RCP_W  = 25;

  localparam logic [SEED_W-1:0]   SEED_RST  = '0;
  localparam logic [FREQ_W-1:0]   FREQ_RST  = FREQ_W'(10486);
  localparam logic [OCTCFG_W-1:0] OCT_RST   = OCTCFG_W'(4);
  localparam logic [SCALE_W-1:0]  SCALE_RST = SCALE_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED    = 2'd0,
    REG_FREQ    = 2'd1,
    REG_OCTAVES = 2'd2,
    REG_SCALE   = 2'd3
  } cfg_reg_t;

  // Data handed from one octave cell to the next.
  typedef struct packed {
    logic                    vld;
    logic [PROD_W-1:0]       px;
    logic [PROD_W-1:0]       py;
    logic signed [SUM_W-1:0] sum;
  } link_t;

  // Normalization factor 2^24 * 2^(n-1) / (2^n - 1), indexed by n-1.
  function automatic logic [RCP_W-1:0] recip_lut(input logic [3:0] idx);
    logic [RCP_W-1:0] r;
    case (idx)
      4'd0:    r = 25'd16777216;
      4'd1:    r = 25'd11184811;
      4'd2:    r = 25'd9586981;
      4'd3:    r = 25'd8947849;
      4'd4:    r = 25'd8659208;
      4'd5:    r = 25'd8521761;
      4'd6:    r = 25'd8454660;
      4'd7:    r = 25'd8421505;
      4'd8:    r = 25'd8405024;
      4'd9:    r = 25'd8396808;
      4'd10:   r = 25'd8392706;
      4'd11:   r = 25'd8390657;
      4'd12:   r = 25'd8389632;
      4'd13:   r = 25'd8389120;
      4'd14:   r = 25'd8388864;
      default: r = 25'd8388736;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/fractal_value_noise_height.sv */
// Throughput: one coordinate per cycle when not stalled, set by the chain of octave
// cells, each a seven-stage pipeline; every cell is present whatever the octave count.
// The whole pipeline holds while a finished result waits under stall.
// Reset (synchronous, rst_n low) clears all valid bits and loads the register defaults.
module fractal_value_noise_height (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [fvnh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fvnh_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fvnh_pkg::COORD_BITS-1:0]     in_grid_x,
  input  logic [fvnh_pkg::COORD_BITS-1:0]     in_grid_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fvnh_pkg::HEIGHT_W-1:0]       out_height_value
);
  import fvnh_pkg::*;

  logic [SEED_W-1:0]   seed_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [OCTCFG_W-1:0] octaves_r;
  logic [SCALE_W-1:0]  scale_r;

  logic [CNT_W-1:0] n_eff;
  logic [3:0]       rcp_idx;
  logic             adv;

  link_t front_r;
  link_t chain [MAX_OCTAVES+1];

  logic               v1_r, v2_r, out_valid_r;
  logic signed [59:0] p_r;
  logic [30:0]        u_r;
  logic [HEIGHT_W-1:0] height_r;

  logic signed [63:0] hh, uraw;
  logic [30:0]        u_nxt;
  logic [46:0]        hp;
  logic [HEIGHT_W-1:0] height_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= SEED_RST;
      freq_r    <= FREQ_RST;
      octaves_r <= OCT_RST;
      scale_r   <= SCALE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEED:    seed_r    <= cfg_wr_data[SEED_W-1:0];
        REG_FREQ:    freq_r    <= cfg_wr_data[FREQ_W-1:0];
        REG_OCTAVES: octaves_r <= cfg_wr_data[OCTCFG_W-1:0];
        REG_SCALE:   scale_r   <= cfg_wr_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (octaves_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(octaves_r) > MAX_OCTAVES) begin
      n_eff = CNT_W'(MAX_OCTAVES);
    end else begin
      n_eff = CNT_W'(octaves_r);
    end
    rcp_idx = 4'(n_eff - CNT_W'(1));
  end

  // The pipeline moves whenever the output register is empty or being drained.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.vld <= 1'b0;
    end else if (adv) begin
      front_r.vld <= in_valid;
    end
    if (adv) begin
      front_r.px  <= PROD_W'(in_grid_x) * PROD_W'(freq_r);
      front_r.py  <= PROD_W'(in_grid_y) * PROD_W'(freq_r);
      front_r.sum <= '0;
    end
  end

  assign chain[0] = front_r;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    fvnh_octave_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .oct_idx (OIDX_W'(g)),
      .oct_cnt (n_eff),
      .seed    (seed_r),
      .link_i  (chain[g]),
      .link_o  (chain[g+1])
    );
  end

  always_comb begin
    hh   = 64'(p_r >>> 24) + 64'sd1073741824;
    uraw = hh >>> 1;
    if (uraw < 0) begin
      u_nxt = '0;
    end else if (uraw > 64'sd1073741824) begin
      u_nxt = 31'h4000_0000;
    end else begin
      u_nxt = uraw[30:0];
    end
    hp = 47'(u_r) * 47'(scale_r);
    if (hp[46:30] > 17'd65535) begin
      height_nxt = '1;
    end else begin
      height_nxt = hp[45:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= chain[MAX_OCTAVES].vld;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r      <= 60'($signed(chain[MAX_OCTAVES].sum))
                  * 60'($signed({1'b0, recip_lut(rcp_idx)}));
      u_r      <= u_nxt;
      height_r <= height_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_height_value = height_r;

  a_height_le_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(height_r) <= 32'(scale_r)))
    else $error("height exceeds height scale");

  a_unit_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (u_r <= 31'h4000_0000))
    else $error("normalized value above one");

  a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (out_valid_r && $stable(height_r) && $stable(v2_r)))
    else $error("pipeline moved while output stalled");

endmodule

/* rtl/core/fvnh_octave_cell.sv */
module fvnh_octave_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic [fvnh_pkg::OIDX_W-1:0]     oct_idx,
  input  logic [fvnh_pkg::CNT_W-1:0]      oct_cnt,
  input  logic [fvnh_pkg::SEED_W-1:0]     seed,
  input  fvnh_pkg::link_t                 link_i,
  output fvnh_pkg::link_t                 link_o
);
  import fvnh_pkg::*;

  localparam logic [31:0] CORNER_OFS [4] = '{32'd0, 32'd127, 32'd311, 32'd438};

  function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [20:0] s);
    logic signed [32:0] d;
    logic signed [54:0] p;
    d = $signed({b[31], b}) - $signed({a[31], a});
    p = 55'(d) * 55'($signed({1'b0, s}));
    return a + 32'(p >>> FRAC_BITS);
  endfunction

  function automatic logic [20:0] smooth(input logic [19:0] f, input logic [19:0] f2);
    logic [21:0] t;
    logic [41:0] p;
    t = 22'(3 << FRAC_BITS) - {1'b0, f, 1'b0};
    p = 42'(f2) * 42'(t);
    return p[40:20];
  endfunction

  link_t lk_r [7];

  logic [63:0] wx, wy;
  logic [31:0] ix, iy, k, nb;
  logic [19:0] fx, fy;
  logic [39:0] fxsq, fysq;
  logic [31:0] n1 [4];

  logic [31:0] n1_r [4];
  logic [19:0] fx_r, fy_r, f2x_r, f2y_r;
  logic [31:0] a_r [4];
  logic [31:0] n2_r [4];
  logic [20:0] sx2_r, sy2_r;
  logic [31:0] b_r [4];
  logic [31:0] n3_r [4];
  logic [20:0] sx3_r, sy3_r;
  logic signed [31:0] v_r [4];
  logic [20:0] sx4_r, sy4_r;
  logic signed [31:0] i0_r, i1_r;
  logic [20:0] sy5_r;
  logic signed [31:0] vo_r;

  logic signed [31:0] contrib;
  logic               active;
  link_t              lk_nxt;

  always_comb begin
    wx   = 64'(link_i.px) << oct_idx;
    wy   = 64'(link_i.py) << oct_idx;
    ix   = wx[51:20];
    iy   = wy[51:20];
    fx   = wx[19:0];
    fy   = wy[19:0];
    k    = seed + 32'(oct_idx);
    nb   = ix * 32'd127 + iy * 32'd311 + k * 32'd997;
    fxsq = 40'(fx) * 40'(fx);
    fysq = 40'(fy) * 40'(fy);
    for (int c = 0; c < 4; c++) begin
      n1[c] = ((nb + CORNER_OFS[c]) << 13) ^ (nb + CORNER_OFS[c]);
    end
  end

  always_comb begin
    active  = CNT_W'(oct_idx) < oct_cnt;
    contrib = vo_r >>> oct_idx;
    lk_nxt  = lk_r[5];
    if (active) begin
      lk_nxt.sum = lk_r[5].sum + SUM_W'(contrib);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) lk_r[i] <= '0;
    end else if (adv) begin
      lk_r[0] <= link_i;
      for (int i = 1; i < 6; i++) lk_r[i] <= lk_r[i-1];
      lk_r[6] <= lk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        n1_r[c] <= n1[c];
        a_r[c]  <= n1_r[c] * n1_r[c];
        n2_r[c] <= n1_r[c];
        b_r[c]  <= a_r[c] * 32'd15731 + 32'd789221;
        n3_r[c] <= n2_r[c];
        v_r[c]  <= $signed(32'h4000_0000)
                   - $signed({1'b0, 31'(n3_r[c] * b_r[c] + 32'd1376312589)});
      end
      fx_r  <= fx;
      fy_r  <= fy;
      f2x_r <= fxsq[39:20];
      f2y_r <= fysq[39:20];
      sx2_r <= smooth(fx_r, f2x_r);
      sy2_r <= smooth(fy_r, f2y_r);
      sx3_r <= sx2_r;
      sy3_r <= sy2_r;
      sx4_r <= sx3_r;
      sy4_r <= sy3_r;
      i0_r  <= lerp(v_r[0], v_r[1], sx4_r);
      i1_r  <= lerp(v_r[2], v_r[3], sx4_r);
      sy5_r <= sy4_r;
      vo_r  <= lerp(i0_r, i1_r, sy5_r);
    end
  end

  assign link_o = lk_r[6];

endmodule
